// ===== rtl/nfk_pkg.sv =====
// Shared types and constants for the newest-first top-k file list.
// No dependencies; imported by every module of the block.
package nfk_pkg;

  // Year field of the packed DOS date and its upper limit (exclusive)
  localparam int YEAR_SHIFT = 9;
  localparam int YEAR_LIMIT = 20;

  // Action codes of an input transaction
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NOP    = 2'd3
  } act_t;

  // One stored table entry: key is date in the upper half, time in the lower
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] size;
    logic [15:0] tag;
  } entry_t;

  // One result transaction
  typedef struct packed {
    logic        accepted;
    logic [7:0]  slot;
    logic [8:0]  entry_count;
    logic        read_ok;
    logic [15:0] out_date;
    logic [15:0] out_time;
    logic [31:0] out_size;
    logic [15:0] out_tag;
  } res_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_INS,
    ST_RDW,
    ST_RESP
  } state_t;

endpackage

// ===== rtl/nfk_mem.sv =====
// Entry table RAM: one write port, one read port with registered read data.
// Depends on nfk_pkg for the entry type.
module nfk_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  nfk_pkg::entry_t  wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output nfk_pkg::entry_t  rd_data
);
  import nfk_pkg::*;

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/nfk_cmp.sv =====
// Shared compare unit: new key against one stored entry, plus the year check.
// Depends on nfk_pkg for the entry type and year constants.
module nfk_cmp (
  input  logic [31:0]      key,
  input  nfk_pkg::entry_t  stored,
  input  logic [15:0]      date,
  output logic             newer,
  output logic             year_ok
);
  import nfk_pkg::*;

  // strictly newer: equal keys keep the stored entry first
  assign newer   = key > stored.key;
  // year since 1980 must stay below the limit
  assign year_ok = (date >> YEAR_SHIFT) < 16'(YEAR_LIMIT);

endmodule

// ===== rtl/newest_first_top_k_list.sv =====
// Newest-first top-k file list. Keeps up to CAPACITY entries sorted by packed DOS
// date and time, newest first, in a single-port-per-direction RAM. One transaction
// is handled at a time. An insert walks the table from the last valid slot toward
// slot 0, one slot per cycle through the shared compare unit, moving each older
// entry down one place as it goes, and then writes the new entry. An insert
// rejected on a full table skips the write step. A read fetches its slot through
// the registered RAM read port. A clear, a no-op or an insert rejected on its year
// goes straight to the result step. Each result appears in the same cycle that the
// block is ready again. The RAM read port sets the one-slot-per-cycle walk. A
// finished result waits in an output register while the next transaction is
// accepted. A second result stalls in the last step until the waiting one leaves.
// Depends on nfk_pkg, nfk_mem and nfk_cmp.
module newest_first_top_k_list #(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] entry_date,
  input  logic [15:0] entry_time,
  input  logic [31:0] entry_size,
  input  logic [15:0] entry_tag,
  input  logic [7:0]  read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic [7:0]  slot,
  output logic [8:0]  entry_count,
  output logic        read_ok,
  output logic [15:0] out_date,
  output logic [15:0] out_time,
  output logic [31:0] out_size,
  output logic [15:0] out_tag
);
  import nfk_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW:0]   CAP_NX  = (AW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] n, n_next;
  logic [AW-1:0] pos, pos_next;
  entry_t        ent, ent_next;
  res_t          res, res_next;
  res_t          res_done;
  res_t          out_res;
  logic          out_load;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        wr_data, rd_data;
  logic          newer, year_ok;
  logic [AW:0]   nx;
  logic          read_hit;

  nfk_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  nfk_cmp u_cmp (
    .key     (ent.key),
    .stored  (rd_data),
    .date    (entry_date),
    .newer   (newer),
    .year_ok (year_ok)
  );

  assign in_ready = (state == ST_IDLE);
  assign nx       = {1'b0, n} + (AW + 1)'(1);
  assign read_hit = (32'(read_index) < 32'(count)) && (32'(read_index) < 32'(CAPACITY));

  // result as it leaves the block, with the final entry count
  always_comb begin
    res_done             = res;
    res_done.entry_count = 9'(count);
  end

  // state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    n   <= n_next;
    pos <= pos_next;
    ent <= ent_next;
    res <= res_next;
    if (out_load) begin
      out_res <= res_done;
    end
  end

  // sequencer: next state, table walk and RAM controls
  always_comb begin
    state_next = state;
    count_next = count;
    n_next     = n;
    pos_next   = pos;
    ent_next   = ent;
    res_next   = res;
    out_load   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = n;
    wr_en      = 1'b0;
    wr_addr    = pos;
    wr_data    = ent;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ent_next = '{key: {entry_date, entry_time}, size: entry_size, tag: entry_tag};
          res_next = '0;
          case (action)
            ACT_CLEAR: begin
              count_next = '0;
              state_next = ST_RESP;
            end
            ACT_INSERT: begin
              if (!year_ok) begin
                state_next = ST_RESP;
              end else if (count == '0) begin
                pos_next   = '0;
                state_next = ST_INS;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = AW'(count - CW'(1));
                n_next     = rd_addr;
                state_next = ST_CMP;
              end
            end
            ACT_READ: begin
              if (read_hit) begin
                rd_en      = 1'b1;
                rd_addr    = AW'(read_index);
                state_next = ST_RDW;
              end else begin
                state_next = ST_RESP;
              end
            end
            default: begin
              state_next = ST_RESP;
            end
          endcase
        end
      end
      ST_CMP: begin
        if (newer) begin
          // move the older entry down; the one past the end drops out
          if (nx < CAP_NX) begin
            wr_en   = 1'b1;
            wr_addr = AW'(nx);
            wr_data = rd_data;
          end
          if (n == '0) begin
            pos_next   = '0;
            state_next = ST_INS;
          end else begin
            rd_en   = 1'b1;
            rd_addr = n - AW'(1);
            n_next  = rd_addr;
          end
        end else if (nx == CAP_NX) begin
          // full table and nothing older: reject
          state_next = ST_RESP;
        end else begin
          pos_next   = AW'(nx);
          state_next = ST_INS;
        end
      end
      ST_INS: begin
        wr_en   = 1'b1;
        wr_addr = pos;
        wr_data = ent;
        if (count < CAP_CNT) begin
          count_next = count + CW'(1);
        end
        res_next.accepted = 1'b1;
        res_next.slot     = 8'(pos);
        state_next        = ST_RESP;
      end
      ST_RDW: begin
        res_next.read_ok  = 1'b1;
        res_next.out_date = rd_data.key[31:16];
        res_next.out_time = rd_data.key[15:0];
        res_next.out_size = rd_data.size;
        res_next.out_tag  = rd_data.tag;
        state_next        = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result ports
  assign accepted    = out_res.accepted;
  assign slot        = out_res.slot;
  assign entry_count = out_res.entry_count;
  assign read_ok     = out_res.read_ok;
  assign out_date    = out_res.out_date;
  assign out_time    = out_res.out_time;
  assign out_size    = out_res.out_size;
  assign out_tag     = out_res.out_tag;

`ifndef SYNTHESIS
  // count never passes the table size
  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= CAP_CNT)
    else $error("entry count above capacity");

  // the walk only visits valid slots
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> 32'(n) < 32'(count))
    else $error("walk index outside valid entries");

  // an insert lands at or before the end of the valid entries
  a_ins_pos: assert property (@(posedge clk) disable iff (rst)
    state == ST_INS |-> 32'(pos) <= 32'(count))
    else $error("insert position past the valid entries");

  // a clear empties the table at once
  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_CLEAR |=> count == '0)
    else $error("clear did not empty the table");
`endif

endmodule

// ===== sim/tb_newest_first_top_k_list.sv =====
// Testbench for newest_first_top_k_list: a mirror of the sorted table predicts
// every result transaction while both channels see random gaps and stalls.
// Depends on nfk_pkg and the block's RTL; needs no files or arguments.
module tb_newest_first_top_k_list;
  import nfk_pkg::*;

  localparam int DEPTH        = 256;
  localparam int N_FILL       = 360;
  localparam int N_MIXED      = 240;
  localparam int IDLE_PCT     = 34;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 12;

  // Mirror of the file table plus the queue of results still owed by the block
  class file_list_checker;
    logic [31:0] key_mirror  [DEPTH];
    logic [31:0] size_mirror [DEPTH];
    logic [15:0] tag_mirror  [DEPTH];
    int          entry_total;
    res_t        pending_results [$];
    int          mismatches;

    function new();
      entry_total = 0;
      mismatches  = 0;
    endfunction

    // Apply one accepted transaction to the mirror and queue its result
    function void apply_action(act_t act, logic [15:0] date, logic [15:0] tstamp,
                               logic [31:0] size, logic [15:0] tag, logic [7:0] idx);
      res_t        r;
      logic [31:0] key;
      int          pos;
      int          n;
      r = '0;
      case (act)
        ACT_CLEAR: begin
          entry_total = 0;
        end
        ACT_INSERT: begin
          key = {date, tstamp};
          // first slot holding a strictly older key, else just past the end
          pos = entry_total;
          for (n = entry_total - 1; n >= 0; n--)
            if (key > key_mirror[n]) pos = n;
          if (pos < DEPTH && (date >> YEAR_SHIFT) < YEAR_LIMIT) begin
            if (entry_total < DEPTH) entry_total++;
            for (n = entry_total - 1; n > pos; n--) begin
              key_mirror[n]  = key_mirror[n-1];
              size_mirror[n] = size_mirror[n-1];
              tag_mirror[n]  = tag_mirror[n-1];
            end
            key_mirror[pos]  = key;
            size_mirror[pos] = size;
            tag_mirror[pos]  = tag;
            r.accepted = 1'b1;
            r.slot     = pos[7:0];
          end
        end
        ACT_READ: begin
          if (idx < entry_total) begin
            r.read_ok  = 1'b1;
            r.out_date = key_mirror[idx][31:16];
            r.out_time = key_mirror[idx][15:0];
            r.out_size = size_mirror[idx];
            r.out_tag  = tag_mirror[idx];
          end
        end
        default: ;
      endcase
      r.entry_count = entry_total[8:0];
      pending_results.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one result transaction against the oldest expectation
    function void compare_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("result transaction with no action outstanding");
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      check_field("accepted",    32'(want.accepted),    32'(got.accepted));
      check_field("slot",        32'(want.slot),        32'(got.slot));
      check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      check_field("read_ok",     32'(want.read_ok),     32'(got.read_ok));
      check_field("out_date",    32'(want.out_date),    32'(got.out_date));
      check_field("out_time",    32'(want.out_time),    32'(got.out_time));
      check_field("out_size",    want.out_size,         got.out_size);
      check_field("out_tag",     32'(want.out_tag),     32'(got.out_tag));
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [1:0]  action     = ACT_NOP;
  logic [15:0] entry_date = '0;
  logic [15:0] entry_time = '0;
  logic [31:0] entry_size = '0;
  logic [15:0] entry_tag  = '0;
  logic [7:0]  read_index = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic        accepted;
  logic [7:0]  slot;
  logic [8:0]  entry_count;
  logic        read_ok;
  logic [15:0] out_date;
  logic [15:0] out_time;
  logic [31:0] out_size;
  logic [15:0] out_tag;

  file_list_checker chk;
  bit          steady = 1'b0;   // no idling on either side while set
  logic [31:0] last_key = '0;   // reused to hit equal keys
  int          idle_cycles = 0;

  newest_first_top_k_list #(.CAPACITY(DEPTH)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .entry_date  (entry_date),
    .entry_time  (entry_time),
    .entry_size  (entry_size),
    .entry_tag   (entry_tag),
    .read_index  (read_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .accepted    (accepted),
    .slot        (slot),
    .entry_count (entry_count),
    .read_ok     (read_ok),
    .out_date    (out_date),
    .out_time    (out_time),
    .out_size    (out_size),
    .out_tag     (out_tag)
  );

  initial forever #6 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Result monitor and no-progress watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        chk.compare_result(res_t'({accepted, slot, entry_count, read_ok,
                                   out_date, out_time, out_size, out_tag}));
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Drive one transaction, with a random gap ahead of it, and wait for acceptance
  task automatic issue_txn(act_t act, logic [15:0] date, logic [15:0] tstamp,
                           logic [31:0] size, logic [15:0] tag, logic [7:0] idx);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    entry_date <= date;
    entry_time <= tstamp;
    entry_size <= size;
    entry_tag  <= tag;
    read_index <= idx;
    do @(posedge clk); while (!in_ready);
    chk.apply_action(act, date, tstamp, size, tag, idx);
  endtask

  // One random transaction; inserts are mostly valid-year entries
  task automatic random_txn(int clear_pct, int read_pct);
    int          pick;
    int          sel;
    act_t        act;
    logic [15:0] date;
    logic [15:0] tstamp;
    logic [7:0]  idx;
    pick = $urandom_range(99);
    if (pick < clear_pct)                 act = ACT_CLEAR;
    else if (pick < clear_pct + 3)        act = ACT_NOP;
    else if (pick < clear_pct + 3 + read_pct) act = ACT_READ;
    else                                  act = ACT_INSERT;

    date   = {7'($urandom_range(19)), 9'($urandom)};
    tstamp = 16'($urandom);
    sel    = $urandom_range(99);
    if (sel < 10)
      {date, tstamp} = last_key;
    else if (sel < 18)
      date[15:9] = 7'($urandom_range(127, 20));
    else if (sel < 25)
      date = 16'($urandom_range(31));
    // full table: a key no newer than any stored one must fall off the end
    if (chk.entry_total == DEPTH && $urandom_range(99) < 15)
      {date, tstamp} = '0;

    if (chk.entry_total > 0 && $urandom_range(99) < 75)
      idx = 8'($urandom_range(chk.entry_total - 1));
    else
      idx = 8'($urandom);

    if (act == ACT_INSERT) last_key = {date, tstamp};
    issue_txn(act, date, tstamp, $urandom, 16'($urandom), idx);
  endtask

  initial begin
    int i;
    chk = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty read, unused action, key extremes, year limit, equal keys
    issue_txn(ACT_READ,   16'h0000, 16'h0000, 32'h0,        16'h0000, 8'd0);
    issue_txn(ACT_NOP,    16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 8'hFF);
    issue_txn(ACT_INSERT, 16'h0000, 16'h0000, 32'h0,        16'h0000, 8'd0);
    issue_txn(ACT_INSERT, 16'h27FF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 8'd0);
    issue_txn(ACT_INSERT, 16'h2800, 16'h0000, 32'h1,        16'h0001, 8'd0);
    issue_txn(ACT_INSERT, 16'hFFFF, 16'hFFFF, 32'h2,        16'h0002, 8'd0);
    issue_txn(ACT_INSERT, 16'h27FF, 16'hFFFF, 32'h5A5A5A5A, 16'h1234, 8'd0);
    issue_txn(ACT_INSERT, 16'h1234, 16'h8421, 32'h0000A5A5, 16'h00FF, 8'd0);
    for (i = 0; i < 4; i++)
      issue_txn(ACT_READ, 16'h0, 16'h0, 32'h0, 16'h0, 8'(i));
    issue_txn(ACT_READ,   16'h0000, 16'h0000, 32'h0,        16'h0000, 8'd4);
    issue_txn(ACT_READ,   16'h0000, 16'h0000, 32'h0,        16'h0000, 8'hFF);
    issue_txn(ACT_CLEAR,  16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 8'hFF);
    issue_txn(ACT_READ,   16'h0000, 16'h0000, 32'h0,        16'h0000, 8'd0);
    issue_txn(ACT_INSERT, 16'h0021, 16'h0000, 32'h12345678, 16'hBEEF, 8'd0);
    issue_txn(ACT_READ,   16'h0000, 16'h0000, 32'h0,        16'h0000, 8'd0);

    // Fill past capacity without clearing, with a stretch of full-rate traffic
    for (i = 0; i < N_FILL; i++) begin
      if (i == 120) steady <= 1'b1;
      if (i == 200) steady <= 1'b0;
      random_txn(0, 10);
    end
    // Mixed traffic with occasional clears
    for (i = 0; i < N_MIXED; i++)
      random_txn(3, 30);
    in_valid <= 1'b0;

    while (chk.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
